// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PLE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_TYPE_W = 3;
  localparam int POS_W      = 5;
  localparam int ENTRY_W    = 32;
  localparam int LEN_W      = 5;

  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_REPLACE = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR   = 3'd4;

  localparam int CELL_OP_W = 2;
  localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 2'd0;
  localparam logic [CELL_OP_W-1:0] CELL_INSERT = 2'd1;
  localparam logic [CELL_OP_W-1:0] CELL_REMOVE = 2'd2;
  localparam logic [CELL_OP_W-1:0] CELL_WRITE  = 2'd3;

  typedef struct packed {
    logic [CELL_OP_W-1:0] op;
    logic [POS_W-1:0]     idx;
  } ple_cmd_t;

endpackage

// File: rtl/core/ple_if.sv
interface ple_req_if import ple_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [POS_W-1:0]      position;
  logic [ENTRY_W-1:0]    entry;

  modport source(output valid, output req_type, output position, output entry,
                 input ready);
  modport sink(input valid, input req_type, input position, input entry,
               output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [ENTRY_W-1:0] read_entry;
  logic [LEN_W-1:0]   length;
  logic               empty_res;

  modport source(output valid, output ok, output read_entry, output length,
                 output empty_res, input ready);
  modport sink(input valid, input ok, input read_entry, input length,
               input empty_res, output ready);
endinterface

// File: rtl/core/positional_list_engine.sv
// positional list engine: ordered list addressed by 1-based position
// req channel carries req_type, position and entry; rsp channel returns
// ok, read_entry, length and empty_res, one response per request
// a request is taken whenever no response is waiting, or in the same
// cycle that the waiting response transfers, so one request per cycle
// is sustained while the receiver keeps ready high
// the response is registered on the transfer edge and is valid in the next cycle
// the list is a row of cells, one per slot; insert and remove shift every
// later slot to its neighbor in that same edge, so no request waits on a
// shift loop
// reset empties the list and drops any pending response; slot contents
// are left as they are and are only read after being written
// when the receiver stalls the response holds and req.ready stays low
// until it transfers
module positional_list_engine import ple_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ple_req_if.sink      req,
  ple_rsp_if.source    rsp
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] sel_data;
  logic [63:0]           entry_ext;
  logic [63:0]           sel_ext;
  ple_cmd_t              cmd;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CMPW-1:0] pos_w;
  logic [CMPW-1:0] cnt_w;
  logic            accept;
  logic            pos_in;
  logic            ins_ok;
  logic            req_ok;

  logic               out_valid;
  logic               out_ok;
  logic [ENTRY_W-1:0] out_read;
  logic [LEN_W-1:0]   out_len;
  logic               out_empty;

  assign accept    = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;

  assign entry_ext = 64'(req.entry);
  assign value     = entry_ext[DATA_WIDTH-1:0];

  assign pos_w  = CMPW'(req.position);
  assign cnt_w  = CMPW'(count);
  assign pos_in = (req.position != '0) && (pos_w <= cnt_w);
  assign ins_ok = (req.position != '0) && (pos_w <= cnt_w + CMPW'(1))
                  && (count < CW'(CAPACITY));

  always_comb begin
    req_ok     = 1'b0;
    count_next = count;
    cmd.op     = CELL_HOLD;
    cmd.idx    = req.position - POS_W'(1);
    case (req.req_type)
      REQ_INSERT: begin
        req_ok = ins_ok;
        if (ins_ok) begin
          count_next = count + CW'(1);
          cmd.op     = CELL_INSERT;
        end
      end
      REQ_REMOVE: begin
        req_ok = pos_in;
        if (pos_in) begin
          count_next = count - CW'(1);
          cmd.op     = CELL_REMOVE;
        end
      end
      REQ_READ: begin
        req_ok = pos_in;
      end
      REQ_REPLACE: begin
        req_ok = pos_in;
        if (pos_in) begin
          cmd.op = CELL_WRITE;
        end
      end
      REQ_CLEAR: begin
        req_ok     = 1'b1;
        count_next = '0;
      end
      default: req_ok = 1'b0;
    endcase
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end

    ple_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .value      (value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  // read select: one-hot or over the cells
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(cmd.idx) == i) begin
        sel_data = sel_data | cell_data[i];
      end
    end
  end

  assign sel_ext = 64'(sel_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok    <= req_ok;
      out_read  <= (req_ok && req.req_type == REQ_READ) ? sel_ext[ENTRY_W-1:0] : '0;
      out_len   <= LEN_W'(count_next);
      out_empty <= (count_next == '0);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.ok         = out_ok;
  assign rsp.read_entry = out_read;
  assign rsp.length     = out_len;
  assign rsp.empty_res  = out_empty;

endmodule

// File: rtl/core/ple_cell.sv
module ple_cell import ple_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  ple_cmd_t              cmd,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data
);

  logic                  at_pos;
  logic                  after_pos;
  logic [DATA_WIDTH-1:0] data_next;

  assign at_pos    = (32'(cmd.idx) == INDEX);
  assign after_pos = (INDEX > 32'(cmd.idx));

  always_comb begin
    data_next = data;
    case (cmd.op)
      CELL_INSERT: begin
        if (after_pos) begin
          data_next = left_data;
        end else if (at_pos) begin
          data_next = value;
        end
      end
      CELL_REMOVE: begin
        if (at_pos || after_pos) begin
          data_next = right_data;
        end
      end
      CELL_WRITE: begin
        if (at_pos) begin
          data_next = value;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: rtl/core/ple_checker.sv
`include "assert_macros.svh"

module ple_checker import ple_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic [REQ_TYPE_W-1:0] req_type,
  input logic [POS_W-1:0]      position,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  ok,
  input logic [ENTRY_W-1:0]    read_entry,
  input logic [LEN_W-1:0]      length,
  input logic                  empty_res
);

  logic req_xfer;

  assign req_xfer = req_valid && req_ready;

  `PLE_ASSERT_SAME(a_reset_idle, clk, rst, $past(rst), !rsp_valid)
  `PLE_ASSERT_NEXT(a_one_cycle, clk, rst, req_xfer, rsp_valid)
  `PLE_ASSERT_NEXT(a_clear, clk, rst, req_xfer && req_type == REQ_CLEAR, ok && length == '0 && empty_res)
  `PLE_ASSERT_NEXT(a_pos_zero, clk, rst, req_xfer && position == '0 && req_type != REQ_CLEAR, !ok && read_entry == '0)
  `PLE_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(ok) && $stable(read_entry) && $stable(length))

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_type   (req.req_type),
  .position   (req.position),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .ok         (rsp.ok),
  .read_entry (rsp.read_entry),
  .length     (rsp.length),
  .empty_res  (rsp.empty_res)
);
